### hdl/rgb565_intensity_downsampler_core_defines.svh
// ----------------------------------------------------------------------------
// RGB565 intensity downsampler: assertion macros
// Shared assertion forms for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef RGB565_INTENSITY_DOWNSAMPLER_CORE_DEFINES_SVH
`define RGB565_INTENSITY_DOWNSAMPLER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define RID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define RID_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rid_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 intensity downsampler package
// Field widths, payload types and register indexes shared by the block.
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam int MAP_SIZE_DEF = 64;

  localparam int COORD_W   = 8;
  localparam int COLOR_W   = 16;
  localparam int MAP_W     = 6;
  localparam int INTEN_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int MIN_WIDTH = 32;
  localparam int MAX_WIDTH = 256;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [COORD_W-1:0] source_column;
    logic [COORD_W-1:0] source_row;
    logic [COLOR_W-1:0] pixel_color;
  } pix_in_t;

  typedef struct packed {
    logic [MAP_W-1:0]   map_row;
    logic [MAP_W-1:0]   map_column;
    logic [INTEN_W-1:0] intensity;
    logic               last_write;
  } map_wr_t;

endpackage

### hdl/rgb565_intensity_downsampler_core.sv
// ----------------------------------------------------------------------------
// RGB565 intensity downsampler core
// A pixel's first map write is shown after the input register, the divider
// and intensity pipelines and the output register. Throughput: one pixel per
// cycle while the output is free; a pixel with two writes holds the output
// register till both are taken. Reset clears valids, sets both sizes to 256.
// ----------------------------------------------------------------------------
module rgb565_intensity_downsampler_core #(
  parameter int MAP_SIZE = rid_pkg::MAP_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rid_pkg::pix_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rid_pkg::map_wr_t                  out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rid_pkg::CFG_W-1:0]         cfg_data
);

  import rid_pkg::*;

  localparam int QW  = $clog2(MAP_SIZE);
  localparam int LAT = (QW > 4) ? QW : 4;
  localparam int NW  = $clog2(256 * MAP_SIZE + 256);

  logic [CFG_W-1:0] src_width_r, src_height_r;
  logic [CFG_W-1:0] weff;
  logic             w_big;

  logic [NW-1:0]    row_num, col_num, width_span;
  logic             ok0, en;

  logic             vld_r [0:LAT];
  logic [NW-1:0]    row_num_r, col_num_r;
  logic [COLOR_W-1:0] color_r;

  logic [QW-1:0]    row_q, col_q;
  logic [CFG_W-1:0] row_rem, col_rem;
  logic [INTEN_W-1:0] inten_lat;

  logic [9:0]       slack;
  logic             first_ok, second_ok, emit, free_nxt;

  logic             out_valid_r, more_r;
  logic [MAP_W-1:0] map_row_r, map_col_r;
  logic [INTEN_W-1:0] inten_r;

  // Config writes must come only while the pipeline is empty; not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= WIDTH_RST;
      src_height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  src_width_r  <= cfg_data;
        REG_SOURCE_HEIGHT: src_height_r <= cfg_data;
      endcase
    end
  end

  assign w_big = src_width_r > CFG_W'(MAX_WIDTH);
  assign weff  = (src_width_r < CFG_W'(MIN_WIDTH)) ? CFG_W'(MIN_WIDTH) : src_width_r;

  // The first map column sampling this pixel is ceil(col * MAP_SIZE / width);
  // the divider then needs a numerator below MAP_SIZE * width.
  assign row_num    = NW'(in_data.source_row) * NW'(MAP_SIZE);
  assign col_num    = NW'(in_data.source_column) * NW'(MAP_SIZE) + NW'(weff) - NW'(1);
  assign width_span = NW'(MAP_SIZE) * NW'(weff);
  assign ok0 = !w_big && ({1'b0, in_data.source_row} < src_height_r)
               && (col_num < width_span);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid && ok0;
      for (int k = 1; k <= LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_num_r <= row_num;
      col_num_r <= col_num;
      color_r   <= in_data.pixel_color;
    end
  end

  rid_div #(
    .NW  (NW),
    .DW  (CFG_W),
    .QW  (QW),
    .LAT (LAT)
  ) u_div_row (
    .clk  (clk),
    .en   (en),
    .num  (row_num_r),
    .den  (src_height_r),
    .quot (row_q),
    .rem  (row_rem)
  );

  rid_div #(
    .NW  (NW),
    .DW  (CFG_W),
    .QW  (QW),
    .LAT (LAT)
  ) u_div_col (
    .clk  (clk),
    .en   (en),
    .num  (col_num_r),
    .den  (weff),
    .quot (col_q),
    .rem  (col_rem)
  );

  rid_inten #(
    .LAT (LAT)
  ) u_inten (
    .clk       (clk),
    .en        (en),
    .color     (color_r),
    .intensity (inten_lat)
  );

  // The row remainder is not needed; only its quotient sets the map row.
  // With q the first candidate column, q * width = col * MAP_SIZE + slack,
  // so each candidate is checked against the next source column by adds alone.
  assign slack     = 10'(weff) - 10'd1 - 10'(col_rem);
  assign first_ok  = slack < 10'(MAP_SIZE);
  assign second_ok = ((slack + 10'(weff)) < 10'(MAP_SIZE))
                     && ((8'(col_q) + 8'd1) < 8'(MAP_SIZE));
  assign emit      = vld_r[LAT] && first_ok && (row_rem == row_rem);

  assign free_nxt = !out_valid_r || (out_ready && !more_r);
  assign en       = free_nxt || !emit;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
    end else if (en && emit) begin
      out_valid_r <= 1'b1;
      more_r      <= second_ok;
    end else if (out_valid_r && out_ready) begin
      if (more_r) begin
        more_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && emit) begin
      map_row_r <= MAP_W'(row_q);
      map_col_r <= MAP_W'(col_q);
      inten_r   <= inten_lat;
    end else if (out_valid_r && out_ready && more_r) begin
      map_col_r <= map_col_r + MAP_W'(1);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.map_row    = map_row_r;
  assign out_data.map_column = map_col_r;
  assign out_data.intensity  = inten_r;
  assign out_data.last_write = !more_r;

endmodule

### hdl/rid_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, padded with pass stages up to the given depth.
// The numerator must be below the divisor shifted left by the quotient width.
// ----------------------------------------------------------------------------
module rid_div #(
  parameter int NW  = 15,
  parameter int DW  = 9,
  parameter int QW  = 6,
  parameter int LAT = 6
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int EW = NW + DW;

  logic [NW-1:0] rem_r [1:LAT];
  logic [QW-1:0] q_r   [1:LAT];

  genvar k;
  generate
    for (k = 1; k <= LAT; k++) begin : g_stage
      logic [NW-1:0] r_in;
      logic [QW-1:0] q_in;
      logic [NW-1:0] rem_nxt;
      logic [QW-1:0] q_nxt;

      if (k == 1) begin : g_first
        assign r_in = num;
        assign q_in = '0;
      end else begin : g_chain
        assign r_in = rem_r[k-1];
        assign q_in = q_r[k-1];
      end

      if (k <= QW) begin : g_bit
        localparam int B = QW - k;
        logic [EW-1:0] dsh;
        logic          hit;
        assign dsh     = EW'(den) << B;
        assign hit     = EW'(r_in) >= dsh;
        assign rem_nxt = hit ? NW'(EW'(r_in) - dsh) : r_in;
        assign q_nxt   = q_in | (QW'(hit) << B);
      end else begin : g_pass
        assign rem_nxt = r_in;
        assign q_nxt   = q_in;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          q_r[k]   <= q_nxt;
        end
      end
    end
  endgenerate

  assign quot = q_r[LAT];
  assign rem  = DW'(rem_r[LAT]);

endmodule

### hdl/rid_inten.sv
// ----------------------------------------------------------------------------
// Pixel intensity pipeline
// Expands RGB565 to 8-bit channels, forms luminance and the intensity
// estimate over four stages, then delays it to the given depth.
// ----------------------------------------------------------------------------
module rid_inten #(
  parameter int LAT = 6
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] color,
  output logic [7:0]  intensity
);

  import rid_pkg::*;

  typedef logic [7:0] lut32_t [32];
  typedef logic [7:0] lut64_t [64];

  function automatic lut32_t build_lut32();
    lut32_t t;
    for (int i = 0; i < 32; i++) t[i] = 8'((i * 255) / 31);
    return t;
  endfunction

  function automatic lut64_t build_lut64();
    lut64_t t;
    for (int i = 0; i < 64; i++) t[i] = 8'((i * 255) / 63);
    return t;
  endfunction

  localparam lut32_t EXP5_LUT = build_lut32();
  localparam lut64_t EXP6_LUT = build_lut64();

  // Reciprocals that give exact quotients over the value ranges seen here.
  localparam int LUM_RECIP   = 5243;
  localparam int LUM_SHIFT   = 19;
  localparam int THIRD_RECIP = 683;
  localparam int THIRD_SHIFT = 11;
  localparam int LUM_FLOOR   = 8;

  logic [7:0]  rr, gg, bb, mx_nxt;
  logic [14:0] sum_nxt;
  logic [14:0] sum_r;
  logic [7:0]  mx1_r;

  logic [27:0] lum_prod;
  logic [7:0]  lum_r, mx2_r;

  logic [9:0]  y_r;
  logic        zero_r;

  logic [19:0] third_prod;
  logic [8:0]  v_full;
  logic [7:0]  inten_nxt;
  logic [7:0]  dly_r [4:LAT];

  always_comb begin
    rr = EXP5_LUT[color[15:11]];
    gg = EXP6_LUT[color[10:5]];
    bb = EXP5_LUT[color[4:0]];
    sum_nxt = 15'(rr) * 15'd30 + 15'(gg) * 15'd59 + 15'(bb) * 15'd11;
    mx_nxt = rr;
    if (gg > mx_nxt) mx_nxt = gg;
    if (bb > mx_nxt) mx_nxt = bb;
  end

  assign lum_prod   = 28'(sum_r) * 28'(LUM_RECIP);
  assign third_prod = 20'(y_r) * 20'(THIRD_RECIP);
  assign v_full     = third_prod[THIRD_SHIFT +: 9];

  always_comb begin
    if (zero_r) begin
      inten_nxt = '0;
    end else if (v_full > 9'd255) begin
      inten_nxt = 8'd255;
    end else begin
      inten_nxt = v_full[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      mx1_r  <= mx_nxt;
      lum_r  <= lum_prod[LUM_SHIFT +: 8];
      mx2_r  <= mx1_r;
      y_r    <= {1'b0, mx2_r, 1'b0} + 10'(lum_r);
      zero_r <= lum_r <= 8'(LUM_FLOOR);
      dly_r[4] <= inten_nxt;
      for (int k = 5; k <= LAT; k++) dly_r[k] <= dly_r[k-1];
    end
  end

  assign intensity = dly_r[LAT];

endmodule

### hdl/rid_checker.sv
// ----------------------------------------------------------------------------
// RGB565 intensity downsampler port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "rgb565_intensity_downsampler_core_defines.svh"

module rid_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rid_pkg::map_wr_t out_data
);

  import rid_pkg::*;

  `RID_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid set after reset")

  `RID_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // With nothing waiting at the output the pipeline must not stall.
  `RID_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with output empty")

  // A write that is not the last of its pixel is followed at once by the next
  // map column of the same row.
  `RID_ASSERT(a_second_write, out_valid && out_ready && !out_data.last_write |=> out_valid && out_data.map_row == $past(out_data.map_row) && out_data.map_column == MAP_W'($past(out_data.map_column) + MAP_W'(1)), "second write out of sequence")

  // Luminance never exceeds the brightest channel, so a non-zero intensity
  // is at least nine.
  `RID_ASSERT(a_inten_floor, out_valid && out_data.intensity != '0 |-> out_data.intensity >= INTEN_W'(9), "intensity below floor")

endmodule

bind rgb565_intensity_downsampler_core rid_checker u_rid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
